// File: rtl/sidt_pkg.sv
// ----------------------------------------------------------------------------
// sidt_pkg
// Shared types and codes of the session identifier table.
// ----------------------------------------------------------------------------
package sidt_pkg;

    // width of one session identifier
    localparam int ID_W = 32;

    // request opcodes, the last one is unused and leaves the table alone
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_ZERO    = 2'd2,
        ST_DUP     = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } t_state;

endpackage

// File: rtl/sidt_slot_ram.sv
// ----------------------------------------------------------------------------
// sidt_slot_ram
// Slot storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sidt_slot_ram
    import sidt_pkg::*;
#(
    parameter int DEPTH = 10,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [ID_W-1:0] i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output logic [ID_W-1:0] o_rd_data
);

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/session_id_table_core.sv
// ----------------------------------------------------------------------------
// session_id_table_core
// Ring-filled table of session identifiers with lookup and compacting remove.
// ----------------------------------------------------------------------------
// zero identifier or unused opcode go straight to the finish state; insert and lookup
// walk the live slots one slot per cycle, and remove also shifts the later slots down
// one item at a time; the next item is taken once the result is registered
// a finished result may wait in the output register; a later result then waits in the finish state
// reset clears count, pointer and handshake state; slots past the count are
// never read, so the slot memory needs no clearing pass
module session_id_table_core
    import sidt_pkg::*;
#(
    parameter int SLOT_COUNT = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_opcode,
    input  logic [ID_W-1:0] i_session_id,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_status,
    output logic            o_replaced_live,
    output logic [3:0]      o_live_count
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [CW-1:0] FULL = CW'(SLOT_COUNT);
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    t_state          r_state, n_state;
    logic [1:0]      r_opcode, n_opcode;
    logic [ID_W-1:0] r_key, n_key;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_pend, n_pend;
    logic [IW-1:0]   r_wr_idx, n_wr_idx;
    t_status         r_res_status, n_res_status;
    logic            r_res_repl, n_res_repl;
    logic            r_out_vld, n_out_vld;
    t_status         r_out_status, n_out_status;
    logic            r_out_repl, n_out_repl;
    logic [3:0]      r_out_count, n_out_count;

    logic            mem_wr_en;
    logic [IW-1:0]   mem_wr_addr;
    logic [ID_W-1:0] mem_wr_data;
    logic            mem_rd_en;
    logic [IW-1:0]   mem_rd_addr;
    logic [ID_W-1:0] mem_rd_data;

    logic            in_accept;
    logic            imm_done;
    logic            hit;
    logic            more;
    logic            out_free;
    logic [CW-1:0]   cnt_dec;
    logic [CW-1:0]   rd_dec;
    logic [CW+3:0]   cnt_ext;

    sidt_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // shared conditions
    assign in_accept = i_in_valid && o_in_ready;
    assign imm_done  = (i_session_id == '0) || (i_opcode == OP_UNUSED);
    assign hit       = r_pend && (mem_rd_data == r_key);
    assign more      = r_rd_idx < r_count;
    assign out_free  = !r_out_vld || i_out_ready;
    assign cnt_dec   = r_count - 1'b1;
    assign rd_dec    = r_rd_idx - 1'b1;
    assign cnt_ext   = {4'b0, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = imm_done ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = (r_opcode == OP_REMOVE) ? S_SHIFT : S_FIN;
                end else if (!more) begin
                    n_state = S_FIN;
                end
            end
            S_SHIFT: begin
                if (!more) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_opcode     = r_opcode;
        n_key        = r_key;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_rd_idx     = r_rd_idx;
        n_pend       = r_pend;
        n_wr_idx     = r_wr_idx;
        n_res_status = r_res_status;
        n_res_repl   = r_res_repl;
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out_status = r_out_status;
        n_out_repl   = r_out_repl;
        n_out_count  = r_out_count;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_wr_idx;
        mem_wr_data  = mem_rd_data;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = r_rd_idx[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_opcode   = i_opcode;
                    n_key      = i_session_id;
                    n_rd_idx   = '0;
                    n_pend     = 1'b0;
                    n_res_repl = 1'b0;
                    if (i_session_id == '0 && i_opcode != OP_UNUSED) begin
                        n_res_status = ST_ZERO;
                    end else begin
                        n_res_status = ST_MISSING;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // match found in the slot read last cycle
                    n_pend = 1'b0;
                    case (r_opcode)
                        OP_INSERT: n_res_status = ST_DUP;
                        OP_LOOKUP: n_res_status = ST_OK;
                        OP_REMOVE: begin
                            n_res_status = ST_OK;
                            n_wr_idx     = rd_dec[IW-1:0];
                        end
                        default: n_res_status = ST_MISSING;
                    endcase
                end else if (more) begin
                    // fetch the next live slot
                    mem_rd_en = 1'b1;
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    // walk ended without a match
                    n_pend = 1'b0;
                    if (r_opcode == OP_INSERT) begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = r_ptr;
                        mem_wr_data  = r_key;
                        n_res_status = ST_OK;
                        n_res_repl   = (r_count == FULL);
                        if (r_count != FULL) begin
                            n_count = r_count + 1'b1;
                        end
                        n_ptr = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
                    end else begin
                        n_res_status = ST_MISSING;
                    end
                end
            end
            S_SHIFT: begin
                // move each later slot down by one
                if (r_pend) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_wr_idx;
                    mem_wr_data = mem_rd_data;
                    n_wr_idx    = r_wr_idx + 1'b1;
                end
                if (more) begin
                    mem_rd_en = 1'b1;
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_count = cnt_dec;
                    n_ptr   = cnt_dec[IW-1:0];
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_repl   = r_res_repl;
                    n_out_count  = cnt_ext[3:0];
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_opcode     <= n_opcode;
        r_key        <= n_key;
        r_rd_idx     <= n_rd_idx;
        r_wr_idx     <= n_wr_idx;
        r_res_status <= n_res_status;
        r_res_repl   <= n_res_repl;
        r_out_status <= n_out_status;
        r_out_repl   <= n_out_repl;
        r_out_count  <= n_out_count;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_replaced_live = r_out_repl;
    assign o_live_count    = r_out_count;

endmodule

// File: rtl/sidt_checker.sv
// ----------------------------------------------------------------------------
// sidt_checker
// Port-level checks of the session identifier table, bound to the top level.
// ----------------------------------------------------------------------------
module sidt_checker
    import sidt_pkg::*;
#(
    parameter int SLOT_COUNT = 10
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [1:0]      o_status,
    input logic            o_replaced_live,
    input logic [3:0]      o_live_count
);

    localparam logic [3:0] FULL_LOW = 4'(SLOT_COUNT % 16);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_replaced_live) && $stable(o_live_count))
        else $error("result changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an item was taken");

    // overwrite only on a successful insert
    a_repl_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_replaced_live |-> o_status == ST_OK)
        else $error("replaced flag with a failing status");

    // overwrite only when the table is full
    a_repl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_replaced_live |-> o_live_count == FULL_LOW)
        else $error("replaced flag with a table that is not full");

endmodule

bind session_id_table_core sidt_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_sidt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_replaced_live (o_replaced_live),
    .o_live_count    (o_live_count)
);

// File: tb/session_id_table_core_tb.sv
// ----------------------------------------------------------------------------
// session_id_table_core_tb
// Self-checking bench for the session identifier table. A scoreboard class
// keeps its own copy of the slots and the ring pointer and works out the
// status, the replacement flag and the live count of every accepted item.
// A short directed part covers zero identifiers, the unused opcode,
// duplicates, wrap-around overwrite and compacting removes. A random part
// follows in which ids are drawn mostly from a small pool and from the live
// table, so that hits, duplicates and removes are common. The sender runs in
// bursts and the receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module session_id_table_core_tb;
    import sidt_pkg::*;

    localparam int SLOTS        = 10;
    localparam int RANDOM_ITEMS = 850;
    localparam int POOL_SIZE    = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4 * SLOTS + 20;
    localparam int PRINT_CAP    = 40;

    // receiver stall modes
    localparam int RX_OPEN    = 0;
    localparam int RX_PATTERN = 1;
    localparam int RX_SPARSE  = 2;

    // expected result of one item
    typedef struct {
        t_status   status;
        bit        replaced;
        bit [3:0]  live;
    } t_table_result;

    // shadow table and queue of expected results
    class session_table_sb;
        bit [ID_W-1:0]  slots [SLOTS];
        int             ptr;
        t_table_result  pending_q [$];
        int             mismatches;
        int             n_results;
        int             n_printed;
        int             n_replaced;
        int             n_dup;
        int             n_removed;
        int             n_found;

        function void clear();
            foreach (slots[i]) slots[i] = '0;
            ptr = 0;
        endfunction

        function int find(bit [ID_W-1:0] key);
            for (int i = 0; i < SLOTS; i++)
                if (slots[i] == key) return i;
            return SLOTS;
        endfunction

        function int live();
            int n;
            n = 0;
            foreach (slots[i]) if (slots[i] != '0) n++;
            return n;
        endfunction

        // pack live entries to the front, pointer follows the count
        function void compact();
            int w;
            bit [ID_W-1:0] v;
            w = 0;
            for (int r = 0; r < SLOTS; r++) begin
                if (slots[r] != '0) begin
                    v = slots[r];
                    slots[r] = '0;
                    slots[w] = v;
                    w++;
                end
            end
            ptr = w % SLOTS;
        endfunction

        // apply one accepted item and queue its result
        function void note(logic [1:0] op, logic [ID_W-1:0] key);
            t_table_result r;
            int idx;
            r.status   = ST_MISSING;
            r.replaced = 1'b0;
            if (op != OP_UNUSED && key == '0) begin
                r.status = ST_ZERO;
            end else if (op == OP_INSERT) begin
                if (find(key) < SLOTS) begin
                    r.status = ST_DUP;
                end else begin
                    r.replaced = (slots[ptr] != '0);
                    slots[ptr] = key;
                    ptr = (ptr + 1) % SLOTS;
                    r.status = ST_OK;
                end
            end else if (op == OP_LOOKUP) begin
                r.status = (find(key) < SLOTS) ? ST_OK : ST_MISSING;
            end else if (op == OP_REMOVE) begin
                idx = find(key);
                if (idx < SLOTS) begin
                    slots[idx] = '0;
                    compact();
                    r.status = ST_OK;
                end
            end
            r.live = 4'(live());
            pending_q.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            if (n_printed < PRINT_CAP) begin
                n_printed++;
                $display("mismatch at result %0d: %s", n_results, msg);
            end
        endtask

        // compare one accepted result with the oldest expectation
        task check(logic [1:0] status, logic replaced, logic [3:0] live_cnt);
            t_table_result want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result, status %0d", status));
            end else begin
                want = pending_q.pop_front();
                if (status !== want.status)
                    report($sformatf("status got %0d expected %0d", status, want.status));
                if (replaced !== want.replaced)
                    report($sformatf("replaced_live got %0d expected %0d",
                                     replaced, want.replaced));
                if (live_cnt !== want.live)
                    report($sformatf("live_count got %0d expected %0d",
                                     live_cnt, want.live));
                if (want.replaced) n_replaced++;
                if (want.status == ST_DUP) n_dup++;
                if (want.status == ST_OK) n_found++;
            end
            n_results++;
        endtask
    endclass

    // clock, reset and block inputs
    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic [1:0]      i_opcode = OP_INSERT;
    logic [ID_W-1:0] i_session_id = '0;
    logic            i_out_ready = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    logic [1:0]      o_status;
    logic            o_replaced_live;
    logic [3:0]      o_live_count;

    session_table_sb sb;
    bit [ID_W-1:0]   id_pool [POOL_SIZE];
    int              burst_left = 0;
    int              n_sent = 0;
    int              cycle_cnt = 0;
    int              rx_left = 0;
    int              rx_mode = RX_OPEN;
    bit [15:0]       rx_pattern = '1;

    session_id_table_core #(
        .SLOT_COUNT (SLOTS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_session_id    (i_session_id),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_replaced_live (o_replaced_live),
        .o_live_count    (o_live_count)
    );

    // 12 unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items sent", cycle_cnt, n_sent);
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall pattern, changes mode when its random run length runs out
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_left    <= $urandom_range(16, 128);
            rx_mode    <= $urandom_range(RX_OPEN, RX_SPARSE);
            rx_pattern <= 16'($urandom);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:    i_out_ready <= 1'b1;
            RX_PATTERN: i_out_ready <= rx_pattern[rx_left % 16];
            default:    i_out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check(o_status, o_replaced_live, o_live_count);
    end

    // drive one item, wait for it to be taken, then maybe pause
    task send_item(logic [1:0] op, logic [ID_W-1:0] key);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_session_id <= key;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note(op, key);
        n_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            repeat ($urandom_range(0, 12)) begin
                @(negedge i_clk);
                i_in_valid   <= 1'b0;
                i_opcode     <= 2'($urandom);
                i_session_id <= $urandom;
            end
        end else begin
            burst_left--;
        end
    endtask

    function logic [1:0] random_op();
        case ($urandom_range(0, 2))
            0:       return OP_INSERT;
            1:       return OP_LOOKUP;
            default: return OP_REMOVE;
        endcase
    endfunction

    // id from a random slot of the live table, else from the pool if that slot is empty or not asked for
    function bit [ID_W-1:0] pick_id(bit from_table);
        bit [ID_W-1:0] v;
        v = sb.slots[$urandom_range(0, SLOTS - 1)];
        if (!from_table || v == '0) v = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return v;
    endfunction

    initial begin
        int sel;
        int r;
        logic [1:0] op;
        logic [ID_W-1:0] key;

        sb = new();
        foreach (id_pool[i]) begin
            do id_pool[i] = $urandom; while (id_pool[i] == '0);
        end
        sb.clear();

        // hold reset, then release it
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero identifier on insert, lookup and remove
        send_item(OP_INSERT, '0);
        send_item(OP_LOOKUP, '0);
        send_item(OP_REMOVE, '0);
        // unused opcode, with and without an identifier
        send_item(OP_UNUSED, '0);
        send_item(OP_UNUSED, 32'h1234_5678);
        // extreme ids, duplicate insert, hit and miss
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_LOOKUP, 32'h0000_0001);
        send_item(OP_LOOKUP, 32'h0000_0002);
        send_item(OP_REMOVE, 32'h0000_0002);
        // fill past the size so the oldest entry is overwritten
        for (int k = 0; k < 9; k++) send_item(OP_INSERT, 32'h8000_0000 + k);
        // remove from the middle, then the first slot, then refill
        send_item(OP_REMOVE, 32'h8000_0004);
        send_item(OP_REMOVE, 32'h8000_0008);
        send_item(OP_LOOKUP, 32'h8000_0004);
        send_item(OP_INSERT, 32'h7FFF_FFFF);

        // random mix, mostly pool and live ids so hits and duplicates occur
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            sel = $urandom_range(0, 99);
            r   = $urandom_range(0, 9);
            key = (r < 4) ? pick_id(1'b1) : (r < 8) ? pick_id(1'b0) : $urandom;
            if (sel < 40) begin
                op = OP_INSERT;
            end else if (sel < 70) begin
                op = OP_LOOKUP;
            end else if (sel < 94) begin
                op = OP_REMOVE;
            end else if (sel < 97) begin
                op = OP_UNUSED;
                if (r < 3) key = '0;
            end else begin
                op  = random_op();
                key = '0;
            end
            send_item(op, key);
        end

        // drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d results: %0d ok or found, %0d duplicates",
                 n_sent, sb.n_results, sb.n_found, sb.n_dup);
        $display("%0d inserts overwrote a live entry, %0d mismatches",
                 sb.n_replaced, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sidt_pkg.sv
rtl/sidt_slot_ram.sv
rtl/session_id_table_core.sv
rtl/sidt_checker.sv
tb/session_id_table_core_tb.sv
